// ----- rtl/core/drkg_pkg.sv -----
// Shared constants, types and permutation functions of the DES round key generator.
package drkg_pkg;

    localparam int KEY_W    = 64;
    localparam int ROUND_W  = 5;
    localparam int SUBKEY_W = 48;
    localparam int HALF_W   = 28;
    localparam int CD_W     = 2 * HALF_W;
    localparam int SHIFT_W  = 5;
    localparam int ROUNDS   = 17;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [ROUND_W-1:0]  t_round;
    typedef logic [SUBKEY_W-1:0] t_subkey;
    typedef logic [HALF_W-1:0]   t_half;
    typedef logic [CD_W-1:0]     t_cd;
    typedef logic [SHIFT_W-1:0]  t_shift;

    localparam logic [6:0] PC1_TAB [CD_W] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] PC2_TAB [SUBKEY_W] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    localparam logic [SHIFT_W-1:0] TOTAL_SHIFT [ROUNDS] = '{
        5'd0,  5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    function automatic t_cd choice_one(input t_key key);
        t_cd res;
        res = '0;
        for (int i = 0; i < CD_W; i++) begin
            res[CD_W-1-i] = key[KEY_W - int'(PC1_TAB[i])];
        end
        return res;
    endfunction

    function automatic t_subkey choice_two(input t_cd cd);
        t_subkey res;
        res = '0;
        for (int i = 0; i < SUBKEY_W; i++) begin
            res[SUBKEY_W-1-i] = cd[CD_W - int'(PC2_TAB[i])];
        end
        return res;
    endfunction

    function automatic t_half rotl_half(input t_half half, input t_shift amount);
        logic [2*HALF_W-1:0] dbl;
        dbl = {half, half} << amount;
        return dbl[2*HALF_W-1:HALF_W];
    endfunction

endpackage

// ----- rtl/core/drkg_req_if.sv -----
// Request channel carrying a round number.
interface drkg_req_if;
    logic                  valid;
    logic                  ready;
    drkg_pkg::t_round      round_number;

    modport source (output valid, output round_number, input ready);
    modport sink   (input valid, input round_number, output ready);
endinterface

// ----- rtl/core/drkg_rsp_if.sv -----
// Response channel carrying a round subkey.
interface drkg_rsp_if;
    logic                  valid;
    logic                  ready;
    drkg_pkg::t_subkey     round_subkey;

    modport source (output valid, output round_subkey, input ready);
    modport sink   (input valid, input round_subkey, output ready);
endinterface

// ----- rtl/core/drkg_sched.sv -----
// Lookup stage: saturate the round number and look up the cumulative rotation.
module drkg_sched (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  drkg_pkg::t_round    i_round,
    output logic                o_valid,
    input  logic                i_ready,
    output drkg_pkg::t_shift    o_shift
);
    logic             r_valid;
    drkg_pkg::t_shift r_shift;
    drkg_pkg::t_round n_round;

    assign o_ready = !r_valid || i_ready;
    assign n_round = (i_round > drkg_pkg::LAST_ROUND) ? drkg_pkg::LAST_ROUND : i_round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_shift <= drkg_pkg::TOTAL_SHIFT[n_round];
        end
    end

    assign o_valid = r_valid;
    assign o_shift = r_shift;
endmodule

// ----- rtl/core/drkg_rotate.sv -----
// Rotation stage: parity-dropping key permutation and left rotation of both halves.
module drkg_rotate (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  drkg_pkg::t_key      i_key,
    input  logic                i_valid,
    output logic                o_ready,
    input  drkg_pkg::t_shift    i_shift,
    output logic                o_valid,
    input  logic                i_ready,
    output drkg_pkg::t_cd       o_cd
);
    logic            r_valid;
    drkg_pkg::t_cd   r_cd;
    drkg_pkg::t_cd   pc1;
    drkg_pkg::t_half c_rot;
    drkg_pkg::t_half d_rot;

    assign o_ready = !r_valid || i_ready;
    assign pc1     = drkg_pkg::choice_one(i_key);
    assign c_rot   = drkg_pkg::rotl_half(pc1[drkg_pkg::CD_W-1:drkg_pkg::HALF_W], i_shift);
    assign d_rot   = drkg_pkg::rotl_half(pc1[drkg_pkg::HALF_W-1:0], i_shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cd <= {c_rot, d_rot};
        end
    end

    assign o_valid = r_valid;
    assign o_cd    = r_cd;
endmodule

// ----- rtl/core/drkg_select.sv -----
// Output stage: compress the rotated halves into the subkey and hold it in the output register.
module drkg_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  drkg_pkg::t_cd       i_cd,
    output logic                o_valid,
    input  logic                i_ready,
    output drkg_pkg::t_subkey   o_subkey
);
    logic              r_valid;
    drkg_pkg::t_subkey r_subkey;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_subkey <= drkg_pkg::choice_two(i_cd);
        end
    end

    assign o_valid  = r_valid;
    assign o_subkey = r_subkey;
endmodule

// ----- rtl/core/des_round_key_generator.sv -----
// DES round key generator: returns the 48-bit subkey of a requested round.
//
// Load the 64-bit key through i_cfg_wr_en / i_cfg_wr_data while no request
// is in flight; parity bits are ignored. Each request on i_req carries a
// round number 0..16 (larger values give round 16) and yields exactly one
// response on o_rsp carrying the subkey, in request order.
// The datapath is three register stages: rotation lookup, parity-dropping key
// permutation with half rotation, subkey compression into the output register.
// Throughput is one request per cycle, limited by nothing but the stage
// registers and by back-pressure from o_rsp.ready.
// When the receiver holds o_rsp.ready low the response stays on the port and
// the stages behind it keep filling; i_req.ready falls only once all three
// stages hold a request. Nothing is dropped or repeated.
// Reset clears every stage valid bit and sets the key to zero.
module des_round_key_generator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  drkg_pkg::t_key       i_cfg_wr_data,
    drkg_req_if.sink             i_req,
    drkg_rsp_if.source           o_rsp
);
    drkg_pkg::t_key   r_cipher_key;
    logic             s1_valid;
    logic             s1_ready;
    drkg_pkg::t_shift s1_shift;
    logic             s2_valid;
    logic             s2_ready;
    drkg_pkg::t_cd    s2_cd;
    logic             s3_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
        end else if (i_cfg_wr_en) begin
            r_cipher_key <= i_cfg_wr_data;
        end
    end

    drkg_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_round (i_req.round_number),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_shift (s1_shift)
    );

    drkg_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_cipher_key),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_shift (s1_shift),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_cd    (s2_cd)
    );

    drkg_select u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s2_valid),
        .o_ready  (s2_ready),
        .i_cd     (s2_cd),
        .o_valid  (o_rsp.valid),
        .i_ready  (s3_ready),
        .o_subkey (o_rsp.round_subkey)
    );

    assign s3_ready = o_rsp.ready;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!s1_valid && !s2_valid && !o_rsp.valid))
        else $error("pipeline not empty after reset");

    a_req_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> s1_valid)
        else $error("accepted request missing from first stage");

    a_s1_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && s1_ready) |=> s2_valid)
        else $error("first stage request lost on the way to second stage");

    a_s2_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_valid && s2_ready) |=> o_rsp.valid)
        else $error("second stage request lost on the way to output");
endmodule
